// File: design/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// Used by lir_div and linear_interp_resampler_core; depends on nothing else.
package lir_pkg;

    // Field widths fixed by the request and result formats.
    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 19;
    localparam int LIMIT_W  = 16;
    localparam int IDX_W    = 17;
    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    // The shared divider takes a dividend wide enough for a signed interpolation
    // numerator magnitude and for a sample count times a rate.
    localparam int DIV_W     = 36;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Request modes.
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_PULL  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SOURCE_RATE  = 2'd0;
    localparam logic [1:0] CFG_TARGET_RATE  = 2'd1;
    localparam logic [1:0] CFG_OUTPUT_LIMIT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [RATE_W-1:0]  SOURCE_RATE_RST  = 19'd8000;
    localparam logic [RATE_W-1:0]  TARGET_RATE_RST  = 19'd48000;
    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 16'd65535;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [SAMPLE_W-1:0] sample_in;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       out_valid;
        logic                       out_last;
        logic                       load_overflow;
    } res_t;

    // Divider command and status.
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [RATE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [RATE_W-1:0] remainder;
    } div_res_t;

endpackage

// File: design/linear_interp_resampler_core.sv
// Top level of the linear interpolation resampler: sample store, sequencer and result register.
// Depends on lir_pkg and instantiates lir_div.
//
// Clear and load requests are handled in the idle state; a load writes the sample store directly.
// A pull request works through the store and one shared 36-step divider; a pull also folds
// the phase remainder into the index when needed (before and after the sample), and the
// first pull after a clear, load or register write also works out the output count.
// Only one request is in progress at a time, but a finished result waits in the
// output register while the next request is taken. The store has no reset: only entries
// written since the last clear are ever read.
module linear_interp_resampler_core
    import lir_pkg::*;
#(
    parameter int SRC_DEPTH = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [RATE_W-1:0] cfg_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req_data,
    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res_data
);

    localparam int AW = $clog2(SRC_DEPTH);
    localparam int LW = $clog2(SRC_DEPTH + 1);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_TMUL  = 13'b0000000000010,
        S_TDIV  = 13'b0000000000100,
        S_CHECK = 13'b0000000001000,
        S_FOLD1 = 13'b0000000010000,
        S_RD0   = 13'b0000000100000,
        S_RD1   = 13'b0000001000000,
        S_MUL0  = 13'b0000010000000,
        S_MUL1  = 13'b0000100000000,
        S_ADD   = 13'b0001000000000,
        S_IDIV  = 13'b0010000000000,
        S_FOLD2 = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic [RATE_W-1:0]    src_rate_reg, src_rate_next;
    logic [RATE_W-1:0]    tgt_rate_reg, tgt_rate_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [LW-1:0]        count_reg, count_next;
    logic [LIMIT_W-1:0]   total_reg, total_next;
    logic [LIMIT_W-1:0]   oidx_reg, oidx_next;
    logic [IDX_W-1:0]     sidx_reg, sidx_next;
    logic [RATE_W-1:0]    phase_reg, phase_next;
    logic                 ready_reg, ready_next;
    logic                 ovf_reg, ovf_next;
    logic                 res_valid_reg, res_valid_next;
    res_t                 res_reg, res_next;

    // Datapath registers.
    res_t                 pend_reg, pend_next;
    logic signed [37:0]   prod_reg, prod_next;
    logic signed [37:0]   acc_reg, acc_next;
    logic signed [37:0]   num_reg, num_next;
    logic signed [16:0]   diff_reg, diff_next;
    logic [SAMPLE_W-1:0]  s0_raw_reg, s0_raw_next;
    logic [RATE_W:0]      sum_reg, sum_next;

    // Sample store.
    logic [SAMPLE_W-1:0]  mem [SRC_DEPTH];
    logic [SAMPLE_W-1:0]  rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;

    logic signed [17:0]   mul_a;
    logic signed [19:0]   mul_b;
    div_req_t             div_req;
    div_res_t             div_res;

    logic                 accept;
    logic                 res_free;
    logic [17:0]          sidx_ext;
    logic [17:0]          sidx_p1;
    logic [17:0]          count_ext;
    logic signed [15:0]   s0v;
    logic signed [15:0]   s1v;
    logic [37:0]          num_mag;
    logic [15:0]          qlow;
    logic [RATE_W:0]      step_sum;

    // Saturating advance of the source index by a divider quotient.
    function automatic logic [IDX_W-1:0] sat_idx(input logic [IDX_W-1:0] idx,
                                                 input logic [DIV_W-1:0] q);
        logic [IDX_W:0] s;
        s = {1'b0, idx} + {1'b0, q[IDX_W-1:0]};
        if ((|q[DIV_W-1:IDX_W]) || s[IDX_W])
            return IDX_MAX;
        return s[IDX_W-1:0];
    endfunction

    lir_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign accept   = req_valid && !req_stall;
    assign res_free = !res_valid_reg || !res_stall;
    assign sidx_ext  = {1'b0, sidx_reg};
    assign sidx_p1   = sidx_ext + 18'd1;
    assign count_ext = 18'(count_reg);

    // Neighbour samples: past the end reads as zero, a missing right neighbour repeats.
    assign s0v = (sidx_ext < count_ext) ? $signed(s0_raw_reg) : 16'sd0;
    assign s1v = (sidx_p1 < count_ext) ? $signed(rd_data_reg) : s0v;

    assign num_mag  = num_reg[37] ? 38'(-num_reg) : 38'(num_reg);
    assign qlow     = div_res.quotient[15:0];
    assign step_sum = {1'b0, phase_reg} + {1'b0, src_rate_reg};

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (state_reg)
            S_TMUL:
            begin
                mul_a = $signed(18'(count_reg));
                mul_b = $signed({1'b0, tgt_rate_reg});
            end
            S_MUL0:
            begin
                mul_a = {{2{s0v[15]}}, s0v};
                mul_b = $signed({1'b0, tgt_rate_reg});
            end
            S_MUL1:
            begin
                mul_a = {diff_reg[16], diff_reg};
                mul_b = $signed({1'b0, phase_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operand selection; a command starts on the first cycle of a divide state.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = tgt_rate_reg;
        unique case (state_reg)
            S_TDIV:
            begin
                div_req.dividend = prod_reg[DIV_W-1:0];
                div_req.divisor  = src_rate_reg;
            end
            S_FOLD1:
            begin
                div_req.dividend = DIV_W'(phase_reg);
            end
            S_IDIV:
            begin
                div_req.dividend = num_mag[DIV_W-1:0];
            end
            S_FOLD2:
            begin
                div_req.dividend = DIV_W'(sum_reg);
            end
            default:
            begin
                div_req.dividend = '0;
            end
        endcase
        if ((state_reg == S_TDIV || state_reg == S_FOLD1 || state_reg == S_IDIV ||
             state_reg == S_FOLD2) && !div_res.busy && !div_res.done)
        begin
            div_req.start = 1'b1;
        end
    end

    // Sequencer and state update.
    always_comb
    begin
        state_next     = state_reg;
        src_rate_next  = src_rate_reg;
        tgt_rate_next  = tgt_rate_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        oidx_next      = oidx_reg;
        sidx_next      = sidx_reg;
        phase_next     = phase_reg;
        ready_next     = ready_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        pend_next      = pend_reg;
        prod_next      = mul_a * mul_b;
        acc_next       = acc_reg;
        num_next       = num_reg;
        diff_next      = diff_reg;
        s0_raw_next    = s0_raw_reg;
        sum_next       = sum_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_re         = 1'b0;
        mem_raddr      = sidx_reg[AW-1:0];

        // The result register empties when the far side takes it.
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        // Register writes; a write to a used index forces the output count to be worked out again.
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOURCE_RATE:
                begin
                    src_rate_next = cfg_data;
                    ready_next    = 1'b0;
                end
                CFG_TARGET_RATE:
                begin
                    tgt_rate_next = cfg_data;
                    ready_next    = 1'b0;
                end
                CFG_OUTPUT_LIMIT:
                begin
                    limit_next = cfg_data[LIMIT_W-1:0];
                    ready_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_data.mode)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                            oidx_next  = '0;
                            sidx_next  = '0;
                            phase_next = '0;
                            ready_next = 1'b0;
                            ovf_next   = 1'b0;
                        end
                        MODE_LOAD:
                        begin
                            if (count_reg < LW'(SRC_DEPTH))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            ready_next = 1'b0;
                        end
                        MODE_PULL:
                        begin
                            state_next = S_CHECK;
                            if (!ready_reg)
                            begin
                                ready_next = 1'b1;
                                if (src_rate_reg == '0 || tgt_rate_reg == '0 ||
                                    limit_reg == '0)
                                begin
                                    total_next = '0;
                                end
                                else if (src_rate_reg == tgt_rate_reg)
                                begin
                                    total_next = (17'(count_reg) > {1'b0, limit_reg}) ?
                                                 limit_reg : 16'(count_reg);
                                end
                                else
                                begin
                                    state_next = S_TMUL;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TMUL:
            begin
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                // Count is at least one and at most the limit.
                if (div_res.done)
                begin
                    if (div_res.quotient > DIV_W'(limit_reg))
                        total_next = limit_reg;
                    else if (div_res.quotient == '0)
                        total_next = 16'd1;
                    else
                        total_next = qlow;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (oidx_reg >= total_reg || src_rate_reg == '0 || tgt_rate_reg == '0)
                begin
                    pend_next.sample_out    = '0;
                    pend_next.out_valid     = 1'b0;
                    pend_next.out_last      = 1'b0;
                    pend_next.load_overflow = ovf_reg;
                    state_next              = S_EMIT;
                end
                else if (phase_reg >= tgt_rate_reg)
                begin
                    state_next = S_FOLD1;
                end
                else
                begin
                    state_next = S_RD0;
                end
            end
            S_FOLD1:
            begin
                if (div_res.done)
                begin
                    sidx_next  = sat_idx(sidx_reg, div_res.quotient);
                    phase_next = div_res.remainder;
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = sidx_reg[AW-1:0];
                state_next = S_RD1;
            end
            S_RD1:
            begin
                s0_raw_next = rd_data_reg;
                mem_re      = 1'b1;
                mem_raddr   = sidx_p1[AW-1:0];
                state_next  = S_MUL0;
            end
            S_MUL0:
            begin
                diff_next  = {s1v[15], s1v} - {s0v[15], s0v};
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                acc_next   = prod_reg;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                num_next   = acc_reg + prod_reg;
                state_next = S_IDIV;
            end
            S_IDIV:
            begin
                // Signed quotient truncated toward zero, then advance the position.
                if (div_res.done)
                begin
                    pend_next.sample_out    = num_reg[37] ? $signed(-qlow) : $signed(qlow);
                    pend_next.out_valid     = 1'b1;
                    pend_next.out_last      = ({1'b0, oidx_reg} + 17'd1) == {1'b0, total_reg};
                    pend_next.load_overflow = ovf_reg;
                    oidx_next               = oidx_reg + 1'b1;
                    if (step_sum < {1'b0, tgt_rate_reg})
                    begin
                        phase_next = step_sum[RATE_W-1:0];
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sum_next   = step_sum;
                        state_next = S_FOLD2;
                    end
                end
            end
            S_FOLD2:
            begin
                if (div_res.done)
                begin
                    sidx_next  = sat_idx(sidx_reg, div_res.quotient);
                    phase_next = div_res.remainder;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_rate_reg  <= SOURCE_RATE_RST;
            tgt_rate_reg  <= TARGET_RATE_RST;
            limit_reg     <= OUTPUT_LIMIT_RST;
            count_reg     <= '0;
            total_reg     <= '0;
            oidx_reg      <= '0;
            sidx_reg      <= '0;
            phase_reg     <= '0;
            ready_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_rate_reg  <= src_rate_next;
            tgt_rate_reg  <= tgt_rate_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            oidx_reg      <= oidx_next;
            sidx_reg      <= sidx_next;
            phase_reg     <= phase_next;
            ready_reg     <= ready_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        pend_reg   <= pend_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        num_reg    <= num_next;
        diff_reg   <= diff_next;
        s0_raw_reg <= s0_raw_next;
        sum_reg    <= sum_next;
    end

    // Sample store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= req_data.sample_in;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // The store never holds more samples than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LW'(SRC_DEPTH))
        else $error("sample count beyond store depth");

    // The divider is never restarted while it is still working.
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_res.busy)
        else $error("divider started while busy");

    // The phase remainder is folded below the target rate before the store is read.
    a_phase_folded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD0) |-> (phase_reg < tgt_rate_reg))
        else $error("phase remainder not folded before read");

    // A final-sample mark only comes with a real output sample.
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.out_last) |-> res_data.out_valid)
        else $error("last mark on an empty result");

endmodule

// File: design/lir_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on lir_pkg for the command and status structs.
module lir_div
    import lir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [RATE_W-1:0]    dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [RATE_W:0]      trial;
    logic [RATE_W:0]      diff;
    logic                 ge;

    // One shift-and-subtract step on the partial remainder.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits the rate width.
            rem_next = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign res.busy      = busy_reg;
    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

// File: sim/tb_top.sv
// Testbench for linear_interp_resampler_core: directed request sequences and random buffers,
// with every result checked against a behavioural predictor kept in step with each request.
// Depends on lir_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
    import lir_pkg::*;

    localparam int         STORE_DEPTH   = 4096;
    localparam int         STORE_AW      = $clog2(STORE_DEPTH);
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 200;
    localparam int         MAX_REPORTS   = 10;
    localparam int         RANDOM_ITEMS  = 1500;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [1:0]        cfg_index = CFG_SOURCE_RATE;
    logic [RATE_W-1:0] cfg_data  = '0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    req_t              req_data  = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    res_t              res_data;

    // Idling percentages for the sender and the receiver.
    int send_idle_pct = 0;
    int res_stall_pct = 0;

    int mismatch_count   = 0;
    int unexpected_count = 0;
    int report_count     = 0;

    // Results predicted for accepted pull requests, oldest first.
    res_t expected_results[$];

    // Predicted state of the resampler and its registers.
    logic signed [SAMPLE_W-1:0] model_store [STORE_DEPTH];
    longint fill_count   = 0;
    longint output_count = 0;
    longint output_pos   = 0;
    longint read_idx     = 0;
    longint phase_acc    = 0;
    bit     count_valid  = 1'b0;
    bit     dropped_flag = 1'b0;
    longint src_hz       = SOURCE_RATE_RST;
    longint dst_hz       = TARGET_RATE_RST;
    longint count_cap    = OUTPUT_LIMIT_RST;

    linear_interp_resampler_core #(
        .SRC_DEPTH(STORE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #6 clk = ~clk;

    // Register write as the predictor sees it; an unused index changes nothing.
    function automatic void predict_reg_write(input logic [1:0] idx,
                                              input logic [RATE_W-1:0] value);
        case (idx)
            CFG_SOURCE_RATE:  src_hz = value;
            CFG_TARGET_RATE:  dst_hz = value;
            CFG_OUTPUT_LIMIT: count_cap = value[LIMIT_W-1:0];
            default:          return;
        endcase
        count_valid = 1'b0;
    endfunction

    // Move whole steps of the phase remainder into the read index, saturating it.
    function automatic void fold_phase();
        read_idx = read_idx + phase_acc / dst_hz;
        if (read_idx > longint'(IDX_MAX))
            read_idx = longint'(IDX_MAX);
        phase_acc = phase_acc % dst_hz;
    endfunction

    // Update the predicted state for one accepted request and queue any result.
    function automatic void predict_request(input req_t item);
        longint s0;
        longint s1;
        longint num;
        longint quo;
        res_t   exp_res;
        case (item.mode)
            MODE_CLEAR:
            begin
                fill_count   = 0;
                output_count = 0;
                output_pos   = 0;
                read_idx     = 0;
                phase_acc    = 0;
                count_valid  = 1'b0;
                dropped_flag = 1'b0;
            end
            MODE_LOAD:
            begin
                if (fill_count < STORE_DEPTH)
                begin
                    model_store[STORE_AW'(fill_count)] = item.sample_in;
                    fill_count++;
                end
                else
                begin
                    dropped_flag = 1'b1;
                end
                count_valid = 1'b0;
            end
            MODE_PULL:
            begin
                // The output count is worked out once per buffer or setting.
                if (!count_valid)
                begin
                    if (src_hz == 0 || dst_hz == 0 || count_cap == 0)
                        output_count = 0;
                    else if (src_hz == dst_hz)
                        output_count = fill_count;
                    else
                    begin
                        output_count = fill_count * dst_hz / src_hz;
                        if (output_count == 0)
                            output_count = 1;
                    end
                    if (output_count > count_cap)
                        output_count = count_cap;
                    count_valid = 1'b1;
                end
                exp_res = '0;
                exp_res.load_overflow = dropped_flag;
                if (output_pos < output_count && src_hz != 0 && dst_hz != 0)
                begin
                    fold_phase();
                    // Past the end reads as zero; a missing right neighbour repeats the left.
                    s0 = 0;
                    if (read_idx < fill_count)
                        s0 = model_store[STORE_AW'(read_idx)];
                    s1 = s0;
                    if (read_idx + 1 < fill_count)
                        s1 = model_store[STORE_AW'(read_idx + 1)];
                    num = s0 * dst_hz + (s1 - s0) * phase_acc;
                    quo = num / dst_hz;
                    exp_res.sample_out = quo[SAMPLE_W-1:0];
                    exp_res.out_valid  = 1'b1;
                    exp_res.out_last   = (output_pos + 1 == output_count);
                    output_pos++;
                    phase_acc = phase_acc + src_hz;
                    fold_phase();
                end
                expected_results.push_back(exp_res);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one request, wait for it to be taken and update the predictor.
    task automatic send_request(input logic [1:0] mode, input logic [SAMPLE_W-1:0] sample);
        req_t item;
        item.mode      = mode;
        item.sample_in = sample;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_request(item);
    endtask

    task automatic pull_output();
        send_request(MODE_PULL, SAMPLE_W'($urandom));
    endtask

    task automatic clear_buffer();
        send_request(MODE_CLEAR, SAMPLE_W'($urandom));
    endtask

    // Let every outstanding result arrive and the block fall idle.
    task automatic settle_block();
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [RATE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        predict_reg_write(idx, value);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 16'h8000;
        if (pick == 1)
            return 16'h7FFF;
        return SAMPLE_W'($urandom);
    endfunction

    // Often common audio rates, sometimes the extremes, otherwise anything in range.
    function automatic logic [RATE_W-1:0] pick_rate();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            case ($urandom_range(0, 6))
                0:       return 19'd8000;
                1:       return 19'd11025;
                2:       return 19'd22050;
                3:       return 19'd44100;
                4:       return 19'd48000;
                5:       return 19'd96000;
                default: return 19'd192000;
            endcase
        end
        if (pick == 4)
            return 19'd1;
        if (pick == 5)
            return 19'd384000;
        return RATE_W'($urandom_range(1, 384000));
    endfunction

    task automatic write_random_register(input logic [1:0] idx);
        logic [RATE_W-1:0] value;
        case (idx)
            CFG_SOURCE_RATE:
                value = pick_rate();
            CFG_TARGET_RATE:
                value = ($urandom_range(0, 6) == 0) ? src_hz[RATE_W-1:0] : pick_rate();
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       value = 19'd65535;
                    1:       value = RATE_W'($urandom_range(1, 65535));
                    default: value = RATE_W'($urandom_range(1, 32));
                endcase
            end
        endcase
        write_register(idx, value);
    endtask

    // Reset settings: empty buffer, extreme samples and an upsampled read.
    task automatic test_reset_defaults();
        pull_output();
        pull_output();
        send_request(MODE_LOAD, 16'h7FFF);
        send_request(MODE_LOAD, 16'h8000);
        send_request(MODE_LOAD, 16'h0000);
        send_request(MODE_LOAD, 16'hFFFF);
        repeat (3)
            pull_output();
    endtask

    // Equal rates copy samples through, then the buffer runs dry.
    task automatic test_equal_rates();
        settle_block();
        write_register(CFG_SOURCE_RATE, 19'd44100);
        write_register(CFG_TARGET_RATE, 19'd44100);
        clear_buffer();
        send_request(MODE_LOAD, 16'h7FFF);
        send_request(MODE_LOAD, 16'h8000);
        send_request(MODE_LOAD, 16'h0001);
        repeat (4)
            pull_output();
    endtask

    // Zero rates and a zero limit give no outputs; an unused register index is harmless.
    task automatic test_zero_settings();
        clear_buffer();
        send_request(MODE_LOAD, random_sample());
        send_request(MODE_LOAD, random_sample());
        settle_block();
        write_register(CFG_SOURCE_RATE, 19'd0);
        pull_output();
        settle_block();
        write_register(CFG_SOURCE_RATE, 19'd8000);
        write_register(CFG_OUTPUT_LIMIT, 19'd0);
        pull_output();
        settle_block();
        write_register(CFG_OUTPUT_LIMIT, 19'd65535);
        write_register(CFG_TARGET_RATE, 19'd0);
        pull_output();
        settle_block();
        write_register(CFG_UNUSED, 19'h7FFFF);
        write_register(CFG_TARGET_RATE, 19'd48000);
        pull_output();
    endtask

    // A lower target rate mid-buffer leaves a remainder that must be folded first.
    task automatic test_fold_after_rate_change();
        settle_block();
        write_register(CFG_SOURCE_RATE, 19'd44100);
        write_register(CFG_TARGET_RATE, 19'd48000);
        clear_buffer();
        send_request(MODE_LOAD, 16'h7FFF);
        send_request(MODE_LOAD, 16'h8000);
        send_request(MODE_LOAD, 16'h1234);
        send_request(MODE_LOAD, 16'hEDCB);
        repeat (2)
            pull_output();
        settle_block();
        write_register(CFG_TARGET_RATE, 19'd40000);
        repeat (2)
            pull_output();
    endtask

    // Unused mode is ignored; a load after pulling recomputes the count, keeping position.
    task automatic test_unused_mode_and_reload();
        settle_block();
        write_register(CFG_SOURCE_RATE, 19'd8000);
        write_register(CFG_TARGET_RATE, 19'd16000);
        clear_buffer();
        send_request(MODE_LOAD, random_sample());
        send_request(MODE_LOAD, random_sample());
        pull_output();
        send_request(MODE_UNUSED, random_sample());
        send_request(MODE_LOAD, random_sample());
        repeat (3)
            pull_output();
    endtask

    // A huge step drives the read index to saturation; later outputs read zero.
    task automatic test_position_saturation();
        settle_block();
        write_register(CFG_SOURCE_RATE, 19'd384000);
        write_register(CFG_TARGET_RATE, 19'd1);
        clear_buffer();
        repeat (3)
            send_request(MODE_LOAD, random_sample());
        pull_output();
        settle_block();
        write_register(CFG_SOURCE_RATE, 19'd1);
        write_register(CFG_TARGET_RATE, 19'd2);
        repeat (2)
            pull_output();
    endtask

    // Fill the store past its depth, then jump to the last entry and read beyond it.
    task automatic test_store_full();
        settle_block();
        write_register(CFG_SOURCE_RATE, 19'd4095);
        write_register(CFG_TARGET_RATE, 19'd1);
        clear_buffer();
        repeat (STORE_DEPTH + 4)
            send_request(MODE_LOAD, random_sample());
        repeat (2)
            pull_output();
        settle_block();
        write_register(CFG_SOURCE_RATE, 19'd1);
        write_register(CFG_TARGET_RATE, 19'd2);
        repeat (3)
            pull_output();
    endtask

    // Random buffers: mostly clear, loads and pulls, with noise and setting changes.
    task automatic test_random_buffers();
        int sent;
        int n_loads;
        int n_pulls;
        int pick;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 31;
                res_stall_pct = 52;
            end
            else if (sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 52;
                res_stall_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                res_stall_pct = 0;
            end

            if ($urandom_range(0, 1) == 0)
            begin
                settle_block();
                write_random_register(CFG_SOURCE_RATE);
                write_random_register(CFG_TARGET_RATE);
                write_random_register(CFG_OUTPUT_LIMIT);
            end

            // Now and then the clear is left out so the old buffer carries on.
            if ($urandom_range(0, 9) != 0)
            begin
                clear_buffer();
                sent++;
            end

            n_loads = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
            repeat (n_loads)
            begin
                send_request(MODE_LOAD, random_sample());
                sent++;
            end

            n_pulls = $urandom_range(1, 24);
            repeat (n_pulls)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    send_request(MODE_LOAD, random_sample());
                    sent++;
                end
                else if (pick < 10)
                begin
                    send_request(MODE_UNUSED, random_sample());
                end
                else if (pick < 13)
                begin
                    settle_block();
                    write_random_register(2'($urandom_range(0, 2)));
                end
                pull_output();
                sent++;
            end
        end
    endtask

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                unexpected_count++;
                report_count++;
                if (report_count <= MAX_REPORTS)
                    $display("Unexpected result: sample %0d valid %0b last %0b overflow %0b",
                             res_data.sample_out, res_data.out_valid, res_data.out_last,
                             res_data.load_overflow);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_data.sample_out !== want.sample_out ||
                    res_data.out_valid !== want.out_valid ||
                    res_data.out_last !== want.out_last ||
                    res_data.load_overflow !== want.load_overflow)
                begin
                    mismatch_count++;
                    report_count++;
                    if (report_count <= MAX_REPORTS)
                        $display("Mismatch: expected sample %0d valid %0b last %0b ovf %0b, got sample %0d valid %0b last %0b ovf %0b",
                                 want.sample_out, want.out_valid, want.out_last,
                                 want.load_overflow, res_data.sample_out, res_data.out_valid,
                                 res_data.out_last, res_data.load_overflow);
                end
            end
        end
        res_stall <= ($urandom_range(0, 99) < res_stall_pct);
    end

    // Watchdog for a hung block.
    initial
    begin : watchdog
        #80_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin : run
        send_idle_pct = 31;
        res_stall_pct = 52;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_equal_rates();
        test_zero_settings();
        test_fold_after_rate_change();
        test_unused_mode_and_reload();
        test_position_saturation();
        test_store_full();
        test_random_buffers();

        settle_block();
        if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
